>>> rtl/core/hsv_to_rgb_converter_core_assert.svh
// assertion macros used by the checker file
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HSVRGB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HSVRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/hsvrgb_pkg.sv
package hsvrgb_pkg;

   // field widths
   localparam int HUE_W    = 9;
   localparam int COMP_W   = 8;
   localparam int OFFSET_W = 6;
   localparam int PROD_W   = 14;
   localparam int NUM_W    = 22;
   localparam int PNUM_W   = 16;

   // scale constants
   localparam int SECTOR_SPAN   = 60;
   localparam int SECTOR_COUNT  = 6;
   localparam int FULL_SCALE    = 255;
   localparam int PRODUCT_SCALE = 15300;
   localparam int FULL_HALF     = 127;
   localparam int PRODUCT_HALF  = 7650;

   // hue / 60 as multiply by 1093 >> 16, exact for 9-bit hue
   localparam int HUE_RECIP_W  = 11;
   localparam int HUE_RECIP    = 1093;
   localparam int HUE_SHIFT    = 16;
   localparam int HUE_PROD_W   = HUE_W + HUE_RECIP_W;
   localparam int HUE_QUO_W    = 4;

   // x / 255 estimate: multiply by 257 >> 16, low by at most one
   localparam int FULL_RECIP_W = 9;
   localparam int FULL_RECIP   = 257;
   localparam int FULL_SHIFT   = 16;
   localparam int FULL_PROD_W  = PNUM_W + FULL_RECIP_W;

   // x / 15300 estimate: multiply by 274 >> 22, low by at most one
   localparam int TERM_RECIP_W = 9;
   localparam int TERM_RECIP   = 274;
   localparam int TERM_SHIFT   = 22;
   localparam int TERM_PROD_W  = NUM_W + TERM_RECIP_W;

   // pipeline depth and occupancy counter width
   localparam int NUM_STAGES = 6;
   localparam int OCC_W      = $clog2(NUM_STAGES + 1);

   typedef enum logic [2:0] {
      SEC_RED_TO_YELLOW   = 3'd0,
      SEC_YELLOW_TO_GREEN = 3'd1,
      SEC_GREEN_TO_CYAN   = 3'd2,
      SEC_CYAN_TO_BLUE    = 3'd3,
      SEC_BLUE_TO_MAGENTA = 3'd4,
      SEC_MAGENTA_TO_RED  = 3'd5
   } sector_type;

   // load enables for the two divider stages
   typedef struct packed {
      logic load_est;
      logic load_fix;
   } div_en_type;

endpackage

>>> rtl/core/hsv_to_rgb_converter_core.sv
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_hue, req_saturation, req_brightness
// rsp     | out       | rsp_valid, rsp_ready, rsp_red, rsp_green, rsp_blue
//
// six-stage pipeline, one transaction accepted per cycle while the output is not stalled
// stage cut: hue divide, offset and p estimate, products, term numerators,
// reciprocal divide by 15300 as estimate and correction (one unit each for q and t)
// synchronous reset clears the stage valid bits only
// a stage holds while its successor is full and stalled, bubbles are squeezed out
module hsv_to_rgb_converter_core import hsvrgb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [COMP_W-1:0] req_saturation,
   input  logic [COMP_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [COMP_W-1:0] rsp_red,
   output logic [COMP_W-1:0] rsp_green,
   output logic [COMP_W-1:0] rsp_blue
);

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_rdy;
   logic [NUM_STAGES-1:0] upstream_vld;
   logic [NUM_STAGES-1:0] load;

   // stage 1
   logic [HUE_W-1:0]     s1_hue_ff;
   logic [COMP_W-1:0]    s1_sat_ff;
   logic [COMP_W-1:0]    s1_val_ff;
   logic [HUE_QUO_W-1:0] s1_hquo_ff;
   logic [PNUM_W-1:0]    s1_pnum_ff;
   logic [HUE_PROD_W-1:0] hue_prod;
   logic [PNUM_W-1:0]    pnum_in;

   // stage 2
   logic [COMP_W-1:0]   s2_sat_ff;
   logic [COMP_W-1:0]   s2_val_ff;
   sector_type          s2_sector_ff;
   logic [OFFSET_W-1:0] s2_off_ff;
   logic [PNUM_W-1:0]   s2_px_ff;
   logic [COMP_W-1:0]   s2_pest_ff;
   logic [HUE_W-1:0]    hue_base;
   logic [OFFSET_W-1:0] off_in;
   logic [HUE_QUO_W-1:0] sector_raw;
   logic [PNUM_W-1:0]   px_in;
   logic [FULL_PROD_W-1:0] pest_prod;

   // stage 3
   logic [COMP_W-1:0] s3_val_ff;
   sector_type        s3_sector_ff;
   logic [PROD_W-1:0] s3_rs_ff;
   logic [PROD_W-1:0] s3_ts_ff;
   logic [COMP_W-1:0] s3_p_ff;
   logic [PNUM_W-1:0] prem;
   logic [COMP_W-1:0] p_in;

   // stage 4
   logic [COMP_W-1:0] s4_val_ff;
   sector_type        s4_sector_ff;
   logic [COMP_W-1:0] s4_p_ff;
   logic [NUM_W-1:0]  s4_qx_ff;
   logic [NUM_W-1:0]  s4_tx_ff;

   // stages 5 and 6
   logic [COMP_W-1:0] s5_val_ff;
   sector_type        s5_sector_ff;
   logic [COMP_W-1:0] s5_p_ff;
   logic [COMP_W-1:0] s6_val_ff;
   sector_type        s6_sector_ff;
   logic [COMP_W-1:0] s6_p_ff;
   logic [COMP_W-1:0] term_q;
   logic [COMP_W-1:0] term_t;
   div_en_type        div_en;

   // ready ripples back from the output; a stage moves when it is empty or drains
   always_comb begin
      stage_rdy[NUM_STAGES-1] = ~valid_ff[NUM_STAGES-1] | rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = ~valid_ff[i] | stage_rdy[i+1];
      end
   end

   assign upstream_vld = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign load         = stage_rdy & upstream_vld;
   assign valid_in     = load | (~stage_rdy & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_rdy[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // stage 1: hue quotient by reciprocal, p numerator
   assign hue_prod = HUE_PROD_W'(req_hue) * HUE_PROD_W'(HUE_RECIP);
   assign pnum_in  = PNUM_W'(req_brightness) * PNUM_W'(COMP_W'(FULL_SCALE) - req_saturation);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_hue_ff  <= req_hue;
         s1_sat_ff  <= req_saturation;
         s1_val_ff  <= req_brightness;
         s1_hquo_ff <= hue_prod[HUE_SHIFT +: HUE_QUO_W];
         s1_pnum_ff <= pnum_in;
      end
   end

   // stage 2: offset within sector, sector wrap, p quotient estimate
   assign hue_base   = HUE_W'(s1_hquo_ff) * HUE_W'(SECTOR_SPAN);
   assign off_in     = OFFSET_W'(s1_hue_ff - hue_base);
   assign sector_raw = (s1_hquo_ff >= HUE_QUO_W'(SECTOR_COUNT))
                       ? s1_hquo_ff - HUE_QUO_W'(SECTOR_COUNT) : s1_hquo_ff;
   assign px_in      = s1_pnum_ff + PNUM_W'(FULL_HALF);
   assign pest_prod  = FULL_PROD_W'(px_in) * FULL_PROD_W'(FULL_RECIP);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_sat_ff    <= s1_sat_ff;
         s2_val_ff    <= s1_val_ff;
         s2_sector_ff <= sector_type'(sector_raw[2:0]);
         s2_off_ff    <= off_in;
         s2_px_ff     <= px_in;
         s2_pest_ff   <= pest_prod[FULL_SHIFT +: COMP_W];
      end
   end

   // stage 3: offset times saturation, p correction
   assign prem = s2_px_ff - PNUM_W'(s2_pest_ff) * PNUM_W'(FULL_SCALE);
   assign p_in = (prem >= PNUM_W'(FULL_SCALE)) ? s2_pest_ff + 1'b1 : s2_pest_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_val_ff    <= s2_val_ff;
         s3_sector_ff <= s2_sector_ff;
         s3_rs_ff     <= PROD_W'(s2_off_ff) * PROD_W'(s2_sat_ff);
         s3_ts_ff     <= PROD_W'(OFFSET_W'(SECTOR_SPAN) - s2_off_ff) * PROD_W'(s2_sat_ff);
         s3_p_ff      <= p_in;
      end
   end

   // stage 4: rounded numerators for q and t
   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_val_ff    <= s3_val_ff;
         s4_sector_ff <= s3_sector_ff;
         s4_p_ff      <= s3_p_ff;
         s4_qx_ff     <= NUM_W'(s3_val_ff) * NUM_W'(PROD_W'(PRODUCT_SCALE) - s3_rs_ff)
                         + NUM_W'(PRODUCT_HALF);
         s4_tx_ff     <= NUM_W'(s3_val_ff) * NUM_W'(PROD_W'(PRODUCT_SCALE) - s3_ts_ff)
                         + NUM_W'(PRODUCT_HALF);
      end
   end

   // stages 5 and 6: divide by 15300
   assign div_en.load_est = load[4];
   assign div_en.load_fix = load[5];

   hsvrgb_div u_div_q (
      .clock    (clock),
      .en       (div_en),
      .dividend (s4_qx_ff),
      .quotient (term_q)
   );

   hsvrgb_div u_div_t (
      .clock    (clock),
      .en       (div_en),
      .dividend (s4_tx_ff),
      .quotient (term_t)
   );

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_val_ff    <= s4_val_ff;
         s5_sector_ff <= s4_sector_ff;
         s5_p_ff      <= s4_p_ff;
      end
      if (load[5]) begin
         s6_val_ff    <= s5_val_ff;
         s6_sector_ff <= s5_sector_ff;
         s6_p_ff      <= s5_p_ff;
      end
   end

   // sector select onto the color channels
   always_comb begin
      case (s6_sector_ff)
         SEC_RED_TO_YELLOW: begin
            rsp_red = s6_val_ff; rsp_green = term_t;    rsp_blue = s6_p_ff;
         end
         SEC_YELLOW_TO_GREEN: begin
            rsp_red = term_q;    rsp_green = s6_val_ff; rsp_blue = s6_p_ff;
         end
         SEC_GREEN_TO_CYAN: begin
            rsp_red = s6_p_ff;   rsp_green = s6_val_ff; rsp_blue = term_t;
         end
         SEC_CYAN_TO_BLUE: begin
            rsp_red = s6_p_ff;   rsp_green = term_q;    rsp_blue = s6_val_ff;
         end
         SEC_BLUE_TO_MAGENTA: begin
            rsp_red = term_t;    rsp_green = s6_p_ff;   rsp_blue = s6_val_ff;
         end
         default: begin
            rsp_red = s6_val_ff; rsp_green = s6_p_ff;   rsp_blue = term_q;
         end
      endcase
   end

endmodule

>>> rtl/core/hsvrgb_div.sv
module hsvrgb_div import hsvrgb_pkg::*; (
   input  logic              clock,
   input  div_en_type        en,
   input  logic [NUM_W-1:0]  dividend,
   output logic [COMP_W-1:0] quotient
);

   logic [NUM_W-1:0]       dividend_ff;
   logic [COMP_W-1:0]      est_ff;
   logic [COMP_W-1:0]      quotient_ff;
   logic [TERM_PROD_W-1:0] est_prod;
   logic [NUM_W-1:0]       est_back;
   logic [NUM_W-1:0]       remainder;
   logic [COMP_W-1:0]      quotient_in;

   // reciprocal estimate, never above the true quotient
   assign est_prod = TERM_PROD_W'(dividend) * TERM_PROD_W'(TERM_RECIP);

   always_ff @(posedge clock) begin
      if (en.load_est) begin
         dividend_ff <= dividend;
         est_ff      <= est_prod[TERM_SHIFT +: COMP_W];
      end
   end

   // one-step correction from the remainder
   assign est_back    = NUM_W'(est_ff) * NUM_W'(PRODUCT_SCALE);
   assign remainder   = dividend_ff - est_back;
   assign quotient_in = (remainder >= NUM_W'(PRODUCT_SCALE)) ? est_ff + 1'b1 : est_ff;

   always_ff @(posedge clock) begin
      if (en.load_fix) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

>>> rtl/core/hsvrgb_checker.sv
`include "hsv_to_rgb_converter_core_assert.svh"

module hsvrgb_checker import hsvrgb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COMP_W-1:0] rsp_red,
   input logic [COMP_W-1:0] rsp_green,
   input logic [COMP_W-1:0] rsp_blue
);

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             req_fire;
   logic             rsp_fire;

   // transactions in flight, seen from the ports
   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;
   assign occ_in   = occ_ff + OCC_W'(req_fire) - OCC_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // a stalled result keeps its value
   `HSVRGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "stalled result changed")

   // no result without a transaction in flight
   `HSVRGB_ASSERT_SAME(a_rsp_has_src, clock, reset, rsp_valid, occ_ff != '0 || req_fire, "result without transaction in flight")

   // a free output side never blocks the input
   `HSVRGB_ASSERT_SAME(a_no_bubble_stall, clock, reset, rsp_ready, req_ready, "input stalled while output is free")

   // a full pipeline with a stalled output takes nothing more
   `HSVRGB_ASSERT_SAME(a_full_blocks, clock, reset, occ_ff == OCC_W'(NUM_STAGES) && !rsp_ready, !req_ready, "input accepted while pipeline full")

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hsvrgb_pkg::*;

   localparam int RANDOM_PIXELS = 550;
   localparam int CALM_TAIL     = 60;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int TABLE_ROWS    = 22;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [COMP_W-1:0] sat;
      logic [COMP_W-1:0] bright;
      logic              known;
      rgb_type           color;
   } pixel_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [HUE_W-1:0]  req_hue;
   logic [COMP_W-1:0] req_saturation;
   logic [COMP_W-1:0] req_brightness;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [COMP_W-1:0] rsp_red;
   logic [COMP_W-1:0] rsp_green;
   logic [COMP_W-1:0] rsp_blue;

   rgb_type expected_colors[$];
   int      error_count;
   int      cycle_count;
   int      stall_left;
   bit      pace_on;

   // directed pixels: primaries, secondaries, gray, black, rounding ties, hue wrap
   pixel_row_type corner_pixels [TABLE_ROWS] = '{
      '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{9'd200, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
      '{9'd150, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{9'd511, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd30,  8'd255, 8'd1,   1'b1, '{8'd1,   8'd1,   8'd0}},
      '{9'd90,  8'd255, 8'd1,   1'b1, '{8'd1,   8'd1,   8'd0}},
      '{9'd359, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd360, 8'd128, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd419, 8'd200, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd420, 8'd255, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd479, 8'd17,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd480, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd511, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd59,  8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd270, 8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd333, 8'd85,  8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{9'd256, 8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}}
   };

   hsv_to_rgb_converter_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // divide with round to nearest, exact halves go up
   function automatic int unsigned round_div(int unsigned num, int unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // hsv to rgb in exact integer arithmetic
   function automatic rgb_type hsv_to_rgb(logic [HUE_W-1:0] hue, logic [COMP_W-1:0] sat,
                                          logic [COMP_W-1:0] bright);
      sector_type  sec;
      int unsigned h, s, v, off, p_term, q_term, t_term;
      rgb_type     color;
      h = hue;
      s = sat;
      v = bright;
      sec = sector_type'((h / SECTOR_SPAN) % SECTOR_COUNT);
      off = h % SECTOR_SPAN;
      p_term = round_div(v * (FULL_SCALE - s), FULL_SCALE);
      q_term = round_div(v * (PRODUCT_SCALE - off * s), PRODUCT_SCALE);
      t_term = round_div(v * (PRODUCT_SCALE - (SECTOR_SPAN - off) * s), PRODUCT_SCALE);
      case (sec)
         SEC_RED_TO_YELLOW:   color = '{v[7:0], t_term[7:0], p_term[7:0]};
         SEC_YELLOW_TO_GREEN: color = '{q_term[7:0], v[7:0], p_term[7:0]};
         SEC_GREEN_TO_CYAN:   color = '{p_term[7:0], v[7:0], t_term[7:0]};
         SEC_CYAN_TO_BLUE:    color = '{p_term[7:0], q_term[7:0], v[7:0]};
         SEC_BLUE_TO_MAGENTA: color = '{t_term[7:0], p_term[7:0], v[7:0]};
         default:             color = '{v[7:0], p_term[7:0], q_term[7:0]};
      endcase
      return color;
   endfunction

   // append one expected color at the tail of the scoreboard
   function automatic void log_expected(rgb_type color);
      expected_colors = {expected_colors, color};
   endfunction

   // after an optional idle gap, drive one pixel at a falling edge, hold until accepted, log its expected color
   task automatic send_pixel(pixel_row_type row);
      int gap;
      if (pace_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= row.hue;
      req_saturation <= row.sat;
      req_brightness <= row.bright;
      do @(posedge clock); while (!req_ready);
      if (row.known)
         log_expected(row.color);
      else
         log_expected(hsv_to_rgb(row.hue, row.sat, row.bright));
      @(negedge clock);
   endtask

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (pace_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest expected color
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d",
                   rsp_red, rsp_green, rsp_blue);
            error_count++;
         end else begin
            want = expected_colors.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // reset, directed table, random pixels, drain
   initial begin
      pixel_row_type row;
      error_count    = 0;
      cycle_count    = 0;
      stall_left     = 0;
      pace_on        = 1'b1;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      rsp_ready      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++)
         send_pixel(corner_pixels[i]);

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         // idle-free stretches now and then, none at all near the end
         pace_on <= (i < RANDOM_PIXELS - CALM_TAIL) && ((i / 40) % 4 != 3);
         row.known = 1'b0;
         row.color = '0;
         case ($urandom_range(0, 9))
            0:       row.hue = HUE_W'($urandom_range(360, 511));
            1:       row.hue = HUE_W'(SECTOR_SPAN * $urandom_range(0, 5)
                               + ($urandom_range(0, 1) ? 0 : SECTOR_SPAN - 1));
            default: row.hue = HUE_W'($urandom_range(0, 359));
         endcase
         case ($urandom_range(0, 7))
            0:       row.sat = '0;
            1:       row.sat = '1;
            default: row.sat = COMP_W'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 7))
            0:       row.bright = '0;
            1:       row.bright = '1;
            default: row.bright = COMP_W'($urandom_range(0, 255));
         endcase
         send_pixel(row);
      end
      req_valid <= 1'b0;

      while (expected_colors.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_colors.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
